// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the rtl checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is asserted
`define CEL_ASSERT(LBL, CLK, RSTN, PROP, MSG) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) PROP) \
        else $error(MSG);

// clocked assertion that is also checked during reset
`define CEL_ASSERT_ALWAYS(LBL, CLK, PROP, MSG) \
    LBL: assert property (@(posedge CLK) PROP) \
        else $error(MSG);

`endif

// File: rtl/core/cel_pkg.sv
// ----------------------------------------------------------------------------
// cel_pkg
// types and constants of the condition expression lexer
// ----------------------------------------------------------------------------
package cel_pkg;

    // grammar states, one-hot
    typedef enum logic [9:0] {
        ST_VAR_START = 10'b00_0000_0001,
        ST_VAR       = 10'b00_0000_0010,
        ST_OP_START  = 10'b00_0000_0100,
        ST_BANG      = 10'b00_0000_1000,
        ST_VAL_START = 10'b00_0001_0000,
        ST_UNQ       = 10'b00_0010_0000,
        ST_QUOTE     = 10'b00_0100_0000,
        ST_ESC       = 10'b00_1000_0000,
        ST_AFTER     = 10'b01_0000_0000,
        ST_AMP1      = 10'b10_0000_0000
    } state_t;

    // byte roles
    localparam logic [2:0] ROLE_SKIP = 3'd0;
    localparam logic [2:0] ROLE_VAR  = 3'd1;
    localparam logic [2:0] ROLE_OP   = 3'd2;
    localparam logic [2:0] ROLE_VAL  = 3'd3;
    localparam logic [2:0] ROLE_END  = 3'd4;

    // status codes
    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_EXP_VAR  = 3'd1;
    localparam logic [2:0] STAT_EXP_OP   = 3'd2;
    localparam logic [2:0] STAT_EXP_VAL  = 3'd3;
    localparam logic [2:0] STAT_EXP_JOIN = 3'd4;

    // characters
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_BSL    = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // result queue sizing
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // stream widths
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 3;

    // one result transaction
    typedef struct packed {
        logic [2:0] role;
        logic [7:0] ch;
        logic [7:0] clause;
        logic       neg;
        logic [2:0] status;
        logic       last;
    } res_t;

    // character classes
    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_name(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h61) && (c <= 8'h7A)) || (c == CH_USCORE) || (c == CH_DOT);
    endfunction

    function automatic logic is_val(input logic [7:0] c);
        return is_name(c) || (c == CH_DASH);
    endfunction

endpackage

// File: rtl/core/condition_expression_lexer.sv
// ----------------------------------------------------------------------------
// condition_expression_lexer
// byte-serial lexer and grammar checker for name=value / name!=value && ...
// ----------------------------------------------------------------------------
// One character enters per cycle on the input stream; the grammar state is
// updated in the cycle the character is taken and its results go into a
// four-entry result queue that feeds the output stream. Most characters give
// one result, a '!' after a name gives none, and the '=' of a "!=" as well as
// an end marker just after a backslash give two, each sent as its own output
// beat. The input is ready whenever the queue has room for two results, so
// with the output always ready the block runs at one character per cycle and
// results are registered in the queue before output. tlast on the input marks
// the end marker item; tlast on the output marks the final status result.
// ----------------------------------------------------------------------------
module condition_expression_lexer
    import cel_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] char_code
    input  logic                  s_tlast,   // action: end of expression
    // output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] char_out, [15:8] clause_index,
                                             // [16] not_equal, [19:17] status, zero fill
    output logic [OUT_USER_W-1:0] m_tuser,   // [2:0] role
    output logic                  m_tlast    // last
);

    // grammar state
    state_t      state_reg, state_next;
    logic        vs_reg, vs_next;
    logic        neg_reg, neg_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [2:0]  err_reg, err_next;

    // result queue
    res_t              q_mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W-1:0] wr_ptr_inc;
    logic [QCNT_W-1:0] q_cnt_reg, q_cnt_next;

    logic        accept;
    logic        pop;
    logic        push0, push1;
    res_t        res0, res1;
    logic [7:0]  c;
    logic [7:0]  cnt_inc;

    assign c       = s_tdata;
    assign cnt_inc = (cnt_reg == 8'hFF) ? cnt_reg : cnt_reg + 8'd1;

    // per-character grammar step
    always_comb
    begin
        logic       op_path;
        logic       after_path;
        logic [2:0] r0_role;
        logic [7:0] r0_ch;
        logic [7:0] fin_cnt;
        logic [2:0] fin_err;
        res_t       fin;

        state_next = state_reg;
        vs_next    = vs_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        err_next   = err_reg;
        push0      = 1'b0;
        push1      = 1'b0;
        op_path    = 1'b0;
        after_path = 1'b0;
        r0_role    = ROLE_SKIP;
        r0_ch      = 8'd0;
        fin_cnt    = cnt_reg;
        fin_err    = err_reg;
        res0       = '0;
        res1       = '0;
        fin        = '0;

        if (s_tlast)
        begin
            // end marker: close the expression and report
            push0 = 1'b1;
            if (err_reg == STAT_OK)
            begin
                unique case (state_reg)
                    ST_VAR, ST_OP_START, ST_BANG: fin_err = STAT_EXP_OP;
                    ST_VAL_START:                 fin_err = STAT_EXP_VAL;
                    ST_UNQ:                       fin_cnt = cnt_inc;
                    ST_QUOTE:
                    begin
                        if (vs_reg)
                            fin_cnt = cnt_inc;
                        else
                            fin_err = STAT_EXP_VAL;
                    end
                    ST_ESC:                       fin_cnt = cnt_inc;
                    ST_AMP1:                      fin_err = STAT_EXP_JOIN;
                    ST_VAR_START, ST_AFTER:       fin_cnt = cnt_reg;
                    default:                      fin_cnt = cnt_reg;
                endcase
            end
            fin.role   = ROLE_END;
            fin.ch     = 8'd0;
            fin.clause = fin_cnt;
            fin.neg    = 1'b0;
            fin.status = fin_err;
            fin.last   = 1'b1;
            if ((err_reg == STAT_OK) && (state_reg == ST_ESC))
            begin
                // trailing backslash is a literal value character
                res0.role   = ROLE_VAL;
                res0.ch     = CH_BSL;
                res0.clause = cnt_reg;
                res0.neg    = neg_reg;
                res0.status = STAT_OK;
                res0.last   = 1'b0;
                res1        = fin;
                push1       = 1'b1;
            end
            else
            begin
                res0 = fin;
            end
            state_next = ST_VAR_START;
            vs_next    = 1'b0;
            neg_next   = 1'b0;
            cnt_next   = 8'd0;
            err_next   = STAT_OK;
        end
        else
        begin
            push0 = 1'b1;
            if (err_reg == STAT_OK)
            begin
                unique case (state_reg)
                    ST_VAR_START:
                    begin
                        if (is_ws(c))
                            r0_role = ROLE_SKIP;
                        else if (!is_name(c))
                            err_next = STAT_EXP_VAR;
                        else
                        begin
                            neg_next   = 1'b0;
                            state_next = ST_VAR;
                            r0_role    = ROLE_VAR;
                            r0_ch      = c;
                        end
                    end
                    ST_VAR:
                    begin
                        if (is_name(c))
                        begin
                            r0_role = ROLE_VAR;
                            r0_ch   = c;
                        end
                        else
                            op_path = 1'b1;
                    end
                    ST_OP_START: op_path = 1'b1;
                    ST_BANG:
                    begin
                        if (c != CH_EQ)
                            err_next = STAT_EXP_OP;
                        else
                        begin
                            neg_next   = 1'b1;
                            state_next = ST_VAL_START;
                            r0_role    = ROLE_OP;
                            r0_ch      = CH_BANG;
                            push1      = 1'b1;
                        end
                    end
                    ST_VAL_START:
                    begin
                        if (is_ws(c))
                            r0_role = ROLE_SKIP;
                        else if (c == CH_QUOTE)
                        begin
                            vs_next    = 1'b0;
                            state_next = ST_QUOTE;
                        end
                        else if (!is_val(c))
                            err_next = STAT_EXP_VAL;
                        else
                        begin
                            state_next = ST_UNQ;
                            r0_role    = ROLE_VAL;
                            r0_ch      = c;
                        end
                    end
                    ST_QUOTE:
                    begin
                        if (c == CH_QUOTE)
                        begin
                            if (!vs_reg)
                                err_next = STAT_EXP_VAL;
                            else
                            begin
                                cnt_next   = cnt_inc;
                                state_next = ST_AFTER;
                            end
                        end
                        else if (c == CH_BSL)
                            state_next = ST_ESC;
                        else
                        begin
                            vs_next = 1'b1;
                            r0_role = ROLE_VAL;
                            r0_ch   = c;
                        end
                    end
                    ST_ESC:
                    begin
                        vs_next    = 1'b1;
                        state_next = ST_QUOTE;
                        r0_role    = ROLE_VAL;
                        r0_ch      = c;
                    end
                    ST_AMP1:
                    begin
                        if (c != CH_AMP)
                            err_next = STAT_EXP_JOIN;
                        else
                            state_next = ST_VAR_START;
                    end
                    ST_UNQ:
                    begin
                        if (is_val(c))
                        begin
                            r0_role = ROLE_VAL;
                            r0_ch   = c;
                        end
                        else
                        begin
                            cnt_next   = cnt_inc;
                            state_next = ST_AFTER;
                            after_path = 1'b1;
                        end
                    end
                    ST_AFTER: after_path = 1'b1;
                    default:  after_path = 1'b1;
                endcase

                // operator expected: name has ended
                if (op_path)
                begin
                    if (is_ws(c))
                        state_next = ST_OP_START;
                    else if (c == CH_EQ)
                    begin
                        neg_next   = 1'b0;
                        state_next = ST_VAL_START;
                        r0_role    = ROLE_OP;
                        r0_ch      = c;
                    end
                    else if (c == CH_BANG)
                    begin
                        state_next = ST_BANG;
                        push0      = 1'b0;
                    end
                    else
                        err_next = STAT_EXP_OP;
                end

                // join or end expected: value has ended
                if (after_path)
                begin
                    if (is_ws(c))
                        r0_role = ROLE_SKIP;
                    else if (c == CH_AMP)
                        state_next = ST_AMP1;
                    else
                        err_next = STAT_EXP_JOIN;
                end
            end

            res0.role   = r0_role;
            res0.ch     = r0_ch;
            res0.clause = cnt_next;
            res0.neg    = neg_next;
            res0.status = err_next;
            res0.last   = 1'b0;
            res1        = res0;
            res1.ch     = CH_EQ;
        end
    end

    // queue control
    assign s_tready    = (q_cnt_reg <= QCNT_W'(QDEPTH - 2));
    assign accept      = s_tvalid && s_tready;
    assign m_tvalid    = (q_cnt_reg != '0);
    assign pop         = m_tvalid && m_tready;
    assign wr_ptr_inc  = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (accept && push1)
            wr_ptr_next = wr_ptr_reg + QPTR_W'(2);
        else if (accept && push0)
            wr_ptr_next = wr_ptr_inc;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        q_cnt_next  = q_cnt_reg
                    + QCNT_W'(accept && push0)
                    + QCNT_W'(accept && push1)
                    - QCNT_W'(pop);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_VAR_START;
            vs_reg     <= 1'b0;
            neg_reg    <= 1'b0;
            cnt_reg    <= 8'd0;
            err_reg    <= STAT_OK;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
                vs_reg    <= vs_next;
                neg_reg   <= neg_next;
                cnt_reg   <= cnt_next;
                err_reg   <= err_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            q_cnt_reg  <= q_cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (accept && push0)
            q_mem_reg[wr_ptr_reg] <= res0;
        if (accept && push1)
            q_mem_reg[wr_ptr_inc] <= res1;
    end

    // output transaction
    always_comb
    begin
        res_t head;
        head    = q_mem_reg[rd_ptr_reg];
        m_tdata = {4'b0000, head.status, head.neg, head.clause, head.ch};
        m_tuser = head.role;
        m_tlast = head.last;
    end

endmodule

// File: rtl/core/cel_checker.sv
// ----------------------------------------------------------------------------
// cel_checker
// port-level assertions for the condition expression lexer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cel_checker
    import cel_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [OUT_USER_W-1:0] m_tuser,
    input logic                  m_tlast
);

    // no result shown while in reset
    `CEL_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |-> !m_tvalid, "output valid during reset")

    // stalled transaction holds its payload
    `CEL_ASSERT(a_stall_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled output changed")

    // tlast marks exactly the final status result
    `CEL_ASSERT(a_last_role, clk, rst_n, m_tvalid |-> (m_tlast == (m_tuser == ROLE_END)), "tlast and final role disagree")

    // final result carries no character and no operator flag
    `CEL_ASSERT(a_final_clean, clk, rst_n, m_tvalid && m_tlast |-> (m_tdata[7:0] == 8'd0) && !m_tdata[16], "final result has char or not_equal set")

    // tagged characters only appear while no error is held
    `CEL_ASSERT(a_tag_no_err, clk, rst_n, m_tvalid && ((m_tuser == ROLE_VAR) || (m_tuser == ROLE_OP) || (m_tuser == ROLE_VAL)) |-> (m_tdata[19:17] == STAT_OK), "tagged char with error status")

endmodule

bind condition_expression_lexer cel_checker u_cel_checker (.*);
